// ===== sv/wwte_pkg.sv =====
// Package for the weighted window time estimator: sizes, weight table,
// state and sequencing codes. No dependencies.
`default_nettype none

package wwte_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    localparam int CMD_W        = 1;
    localparam int TIME_W       = 32;
    localparam int SIZE_W       = 16;
    localparam int FILES_W      = 31;
    localparam int FRAC_W       = 16;
    localparam int ENTRY_W      = TIME_W + FRAC_W;
    localparam int WEIGHT_W     = 16;
    localparam int PROD_W       = ENTRY_W + WEIGHT_W;
    localparam int ACC_W        = PROD_W + $clog2(WINDOW_DEPTH);

    typedef logic [WINDOW_DEPTH-1:0][WEIGHT_W-1:0] weight_vec_t;

    // sqrt(k) in Q3.13, round to nearest, saturate
    function automatic logic [WEIGHT_W-1:0] weight_q13(input int unsigned k);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        longint unsigned t;
        int              n;
        x = 64'(k) << 26;
        r = 0;
        b = 64'd1 << 17;
        for (n = 0; n < 18; n++)
        begin
            t = r + b;
            if (t * t <= x)
            begin
                r = t;
            end
            b = b >> 1;
        end
        if (x > r * r + r)
        begin
            r = r + 1;
        end
        if (r > 64'hFFFF)
        begin
            r = 64'hFFFF;
        end
        return r[WEIGHT_W-1:0];
    endfunction

    function automatic weight_vec_t build_weights();
        weight_vec_t v;
        int          n;
        for (n = 0; n < WINDOW_DEPTH; n++)
        begin
            v[n] = weight_q13(n + 1);
        end
        return v;
    endfunction

    function automatic longint unsigned weight_sum();
        longint unsigned s;
        int              n;
        s = 0;
        for (n = 0; n < WINDOW_DEPTH; n++)
        begin
            s = s + 64'(weight_q13(n + 1));
        end
        return s;
    endfunction

    localparam weight_vec_t     WEIGHTS = build_weights();
    localparam longint unsigned WSUM    = weight_sum();
    localparam int WSUM_W  = $clog2(WSUM + 1);
    localparam int DVS_W   = (WSUM_W > SIZE_W) ? WSUM_W : SIZE_W;
    localparam int DCNT_W  = $clog2(ACC_W + 1);

    // average by constant reciprocal, one quotient digit at a time
    localparam int DIGIT_W     = WEIGHT_W;
    localparam int AVG_DIGITS  = ENTRY_W / DIGIT_W + 1;
    localparam int AVG_LOW_W   = DIGIT_W * AVG_DIGITS;
    localparam int X_W         = DVS_W + DIGIT_W;
    localparam int RECIP_SHIFT = WSUM_W + WEIGHT_W - 1;
    localparam logic [WEIGHT_W-1:0] RECIP = WEIGHT_W'((64'd1 << RECIP_SHIFT) / WSUM);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_MAC,
        ST_AVG,
        ST_FIN,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        PH_READ,
        PH_MUL,
        PH_ADD
    } phase_t;

    typedef enum logic [1:0] {
        FIN_HI_LO,
        FIN_HI_HI,
        FIN_FRAC
    } fin_op_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

// ===== sv/wwte_in_if.sv =====
// Request channel of the weighted window time estimator.
// Depends on wwte_pkg for field widths.
`default_nettype none

interface wwte_in_if;
    logic                           valid;
    logic                           ready;
    logic [wwte_pkg::CMD_W-1:0]     cmd;
    logic [wwte_pkg::TIME_W-1:0]    batch_time;
    logic [wwte_pkg::SIZE_W-1:0]    batch_size;
    logic [wwte_pkg::FILES_W-1:0]   files_left;

    modport source (output valid, output cmd, output batch_time, output batch_size,
                    output files_left, input ready);
    modport sink   (input valid, input cmd, input batch_time, input batch_size,
                    input files_left, output ready);
endinterface

`default_nettype wire

// ===== sv/wwte_out_if.sv =====
// Result channel of the weighted window time estimator.
// Depends on wwte_pkg for field widths.
`default_nettype none

interface wwte_out_if;
    logic                           valid;
    logic                           ready;
    logic [wwte_pkg::TIME_W-1:0]    time_left;
    logic                           estimate_ready;

    modport source (output valid, output time_left, output estimate_ready, input ready);
    modport sink   (input valid, input time_left, input estimate_ready, output ready);
endinterface

`default_nettype wire

// ===== sv/weighted_window_time_estimator_top.sv =====
// Weighted window time estimator: ring of per-item times, one shared 48x16 multiplier,
// a restoring divider for pushes and an adder under a small sequencer.
// Push: accept, restoring divider steps, ring write; a zero batch size skips the divider.
// Query when ready: accept, MAC over the ring, reciprocal division, scaling, result.
// Query before ready: accept, then a zero result. A waiting result item holds the sequencer; not ready while busy.
// Reset clears pointer, ready flag, sequencer and output valid; ring undefined.
`default_nettype none

module weighted_window_time_estimator_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wwte_in_if.sink    request,
    wwte_out_if.source result
);
    import wwte_pkg::*;

    state_t                 state_reg, state_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic                   ready_flag_reg, ready_flag_next;
    logic                   out_valid_reg, out_valid_next;

    logic [PTR_W-1:0]       idx_reg, idx_next;
    logic [PTR_W-1:0]       i_reg, i_next;
    phase_t                 ph_reg, ph_next;
    fin_op_t                op_reg, op_next;
    logic [DCNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic [ACC_W-1:0]       dvd_reg, dvd_next;
    logic [DVS_W-1:0]       dvs_reg, dvs_next;
    logic [DVS_W-1:0]       rem_reg, rem_next;
    logic [ENTRY_W-1:0]     quo_reg, quo_next;
    logic [DIGIT_W-1:0]     qd_reg, qd_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [FILES_W-1:0]     fl_reg, fl_next;
    logic [TIME_W-1:0]      time_left_reg, time_left_next;
    logic                   est_ready_reg, est_ready_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic [ENTRY_W-1:0]     mem [WINDOW_DEPTH];

    logic                   mem_we;
    logic                   accept;
    logic                   out_free;
    logic [DVS_W:0]         trial;
    logic                   ge;
    logic [DVS_W-1:0]       rem_step;
    logic [X_W-1:0]         digit_x;
    logic [X_W-1:0]         digit_diff;
    logic                   digit_ge;
    logic [DVS_W-1:0]       digit_rem;
    logic [ENTRY_W-1:0]     mul_a;
    logic [WEIGHT_W-1:0]    mul_b;
    logic [PROD_W-1:0]      mul_p;
    logic [ACC_W-1:0]       add_term;
    logic [ACC_W-1:0]       acc_sum;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       idx_inc;

    assign request.ready         = (state_reg == ST_IDLE);
    assign accept                = request.valid && request.ready;
    assign out_free              = !out_valid_reg || result.ready;
    assign result.valid          = out_valid_reg;
    assign result.time_left      = time_left_reg;
    assign result.estimate_ready = est_ready_reg;

    assign wp_inc  = (wp_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign idx_inc = (idx_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : idx_reg + 1'b1;

    // restoring divider step for pushes
    assign trial    = {rem_reg, dvd_reg[ACC_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_step = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];

    // correct the estimated quotient digit by at most one
    assign digit_x    = {rem_reg, dvd_reg[ACC_W-1 -: DIGIT_W]};
    assign digit_diff = digit_x - prod_reg[X_W-1:0];
    assign digit_ge   = (digit_diff >= X_W'(WSUM));
    assign digit_rem  = digit_ge ? DVS_W'(digit_diff - X_W'(WSUM)) : digit_diff[DVS_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        add_term = ACC_W'(prod_reg);
        if (state_reg == ST_MAC)
        begin
            mul_a = rd_data_reg;
            mul_b = WEIGHTS[i_reg];
        end
        else if (state_reg == ST_AVG)
        begin
            if (ph_reg == PH_READ)
            begin
                mul_a = ENTRY_W'(digit_x);
                mul_b = RECIP;
            end
            else
            begin
                mul_a = ENTRY_W'(WSUM);
                mul_b = prod_reg[RECIP_SHIFT +: DIGIT_W];
            end
        end
        else if (state_reg == ST_FIN)
        begin
            case (op_reg)
                FIN_HI_LO:
                begin
                    mul_a    = ENTRY_W'(quo_reg[ENTRY_W-1:FRAC_W]);
                    mul_b    = fl_reg[WEIGHT_W-1:0];
                    add_term = ACC_W'(prod_reg);
                end
                FIN_HI_HI:
                begin
                    mul_a    = ENTRY_W'(quo_reg[ENTRY_W-1:FRAC_W]);
                    mul_b    = WEIGHT_W'(fl_reg[FILES_W-1:WEIGHT_W]);
                    add_term = ACC_W'(prod_reg) << WEIGHT_W;
                end
                FIN_FRAC:
                begin
                    mul_a    = ENTRY_W'(fl_reg);
                    mul_b    = quo_reg[FRAC_W-1:0];
                    add_term = ACC_W'(prod_reg >> FRAC_W);
                end
                default:
                begin
                    mul_a    = '0;
                    mul_b    = '0;
                    add_term = '0;
                end
            endcase
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sum = acc_reg + add_term;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.cmd == CMD_PUSH)
                    begin
                        state_next = (request.batch_size == '0) ? ST_WRITE : ST_DIV;
                    end
                    else
                    begin
                        state_next = ready_flag_reg ? ST_MAC : ST_RESULT;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_MAC:
            begin
                if (ph_reg == PH_ADD && i_reg == PTR_W'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (ph_reg == PH_ADD && div_cnt_reg == DCNT_W'(1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (ph_reg == PH_ADD && op_reg == FIN_FRAC)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wp_next         = wp_reg;
        ready_flag_next = ready_flag_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        idx_next        = idx_reg;
        i_next          = i_reg;
        ph_next         = ph_reg;
        op_next         = op_reg;
        div_cnt_next    = div_cnt_reg;
        dvd_next        = dvd_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        qd_next         = qd_reg;
        acc_next        = acc_reg;
        fl_next         = fl_reg;
        time_left_next  = time_left_reg;
        est_ready_next  = est_ready_reg;
        mem_we          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fl_next  = request.files_left;
                    acc_next = '0;
                    idx_next = wp_reg;
                    i_next   = '0;
                    ph_next  = PH_READ;
                    quo_next = '1;
                    if (request.cmd == CMD_PUSH)
                    begin
                        dvd_next     = ACC_W'({request.batch_time, {FRAC_W{1'b0}}})
                                       << (ACC_W - ENTRY_W);
                        dvs_next     = DVS_W'(request.batch_size);
                        rem_next     = '0;
                        div_cnt_next = DCNT_W'(ENTRY_W);
                    end
                end
            end
            ST_DIV:
            begin
                rem_next     = rem_step;
                dvd_next     = dvd_reg << 1;
                quo_next     = {quo_reg[ENTRY_W-2:0], ge};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            ST_WRITE:
            begin
                mem_we  = 1'b1;
                wp_next = wp_inc;
                if (wp_inc == '0)
                begin
                    ready_flag_next = 1'b1;
                end
            end
            ST_MAC:
            begin
                case (ph_reg)
                    PH_READ:
                    begin
                        ph_next = PH_MUL;
                    end
                    PH_MUL:
                    begin
                        ph_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        acc_next = acc_sum;
                        ph_next  = PH_READ;
                        i_next   = i_reg + 1'b1;
                        idx_next = idx_inc;
                        if (i_reg == PTR_W'(WINDOW_DEPTH - 1))
                        begin
                            dvd_next     = acc_sum << (ACC_W - AVG_LOW_W);
                            rem_next     = DVS_W'(acc_sum[ACC_W-1:AVG_LOW_W]);
                            div_cnt_next = DCNT_W'(AVG_DIGITS);
                        end
                    end
                    default:
                    begin
                        ph_next = PH_READ;
                    end
                endcase
            end
            ST_AVG:
            begin
                case (ph_reg)
                    PH_READ:
                    begin
                        ph_next = PH_MUL;
                    end
                    PH_MUL:
                    begin
                        qd_next = prod_reg[RECIP_SHIFT +: DIGIT_W];
                        ph_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        rem_next     = digit_rem;
                        quo_next     = {quo_reg[ENTRY_W-DIGIT_W-1:0],
                                        qd_reg + DIGIT_W'(digit_ge)};
                        dvd_next     = dvd_reg << DIGIT_W;
                        div_cnt_next = div_cnt_reg - 1'b1;
                        ph_next      = PH_READ;
                        if (div_cnt_reg == DCNT_W'(1))
                        begin
                            acc_next = '0;
                            op_next  = FIN_HI_LO;
                            ph_next  = PH_MUL;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_READ;
                    end
                endcase
            end
            ST_FIN:
            begin
                case (ph_reg)
                    PH_MUL:
                    begin
                        ph_next = PH_ADD;
                    end
                    PH_ADD:
                    begin
                        acc_next = acc_sum;
                        ph_next  = PH_MUL;
                        case (op_reg)
                            FIN_HI_LO: op_next = FIN_HI_HI;
                            FIN_HI_HI: op_next = FIN_FRAC;
                            default:   op_next = FIN_HI_LO;
                        endcase
                    end
                    default:
                    begin
                        ph_next = PH_MUL;
                    end
                endcase
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    est_ready_next = ready_flag_reg;
                    time_left_next = (acc_reg > ACC_W'(32'hFFFF_FFFF)) ? '1
                                                                      : acc_reg[TIME_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            ph_reg         <= PH_READ;
            op_reg         <= FIN_HI_LO;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
            ph_reg         <= ph_next;
            op_reg         <= op_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        i_reg         <= i_next;
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        qd_reg        <= qd_next;
        acc_reg       <= acc_next;
        fl_reg        <= fl_next;
        time_left_reg <= time_left_next;
        est_ready_reg <= est_ready_next;
        prod_reg      <= mul_p;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= quo_reg;
        end
        rd_data_reg <= mem[idx_reg];
    end

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result item raised outside the result step");

    a_zero_when_unready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !est_ready_reg) |-> (time_left_reg == '0))
        else $error("non-zero estimate before the ring was filled");

    a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ready_flag_reg |=> ready_flag_reg)
        else $error("ready flag dropped");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg != '0))
        else $error("divider running with exhausted count");

    a_ptr_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (wp_reg != $past(wp_reg)))
        else $error("write pointer did not advance after a ring write");

endmodule

`default_nettype wire

// ===== verif/weighted_window_time_estimator_top_test.sv =====
// Self-checking test of the weighted window time estimator: directed and random items
// are checked against a scoreboard that keeps its own ring of per-item times.
// Depends on wwte_pkg, wwte_in_if, wwte_out_if and weighted_window_time_estimator_top.
`timescale 1ns / 100ps

typedef struct packed {
    logic [wwte_pkg::TIME_W-1:0] time_left;
    logic                        estimate_ready;
} estimate_t;

class estimate_ledger;
    logic [wwte_pkg::ENTRY_W-1:0]  ring_times [wwte_pkg::WINDOW_DEPTH];
    logic [wwte_pkg::WEIGHT_W-1:0] root_weights [wwte_pkg::WINDOW_DEPTH];
    logic [31:0]                   weight_total;
    int unsigned                   oldest_slot;
    bit                            ring_full;
    estimate_t                     pending [$];
    int unsigned                   failures;

    function new();
        weight_total = 0;
        for (int k = 0; k < wwte_pkg::WINDOW_DEPTH; k++)
        begin
            root_weights[k] = root_weight(k + 1);
            weight_total    = weight_total + 32'(root_weights[k]);
            ring_times[k]   = '0;
        end
        oldest_slot = 0;
        ring_full   = 1'b0;
        failures    = 0;
    endfunction

    // sqrt(k) in Q3.13, nearest, saturated
    function logic [wwte_pkg::WEIGHT_W-1:0] root_weight(int unsigned k);
        logic [63:0] scaled;
        logic [63:0] root;
        scaled = 64'(k) << 26;
        root   = 64'($rtoi($sqrt(real'(scaled))));
        while (root * root > scaled)
        begin
            root = root - 1;
        end
        while ((root + 1) * (root + 1) <= scaled)
        begin
            root = root + 1;
        end
        if (scaled > root * root + root)
        begin
            root = root + 1;
        end
        if (root > 64'hFFFF)
        begin
            root = 64'hFFFF;
        end
        return root[wwte_pkg::WEIGHT_W-1:0];
    endfunction

    function logic [wwte_pkg::TIME_W-1:0] scaled_estimate(logic [wwte_pkg::FILES_W-1:0] files);
        logic [127:0] acc;
        logic [127:0] avg;
        logic [63:0]  whole;
        logic [63:0]  part;
        int unsigned  slot;
        acc  = '0;
        slot = oldest_slot;
        for (int k = 0; k < wwte_pkg::WINDOW_DEPTH; k++)
        begin
            acc  = acc + 128'(ring_times[slot]) * 128'(root_weights[k]);
            slot = (slot + 1) % wwte_pkg::WINDOW_DEPTH;
        end
        avg   = acc / 128'(weight_total);
        whole = 64'(avg[47:16]) * 64'(files);
        part  = (64'(avg[15:0]) * 64'(files)) >> 16;
        if (whole > 64'hFFFF_FFFF || whole + part > 64'hFFFF_FFFF)
        begin
            return '1;
        end
        return 32'(whole + part);
    endfunction

    function void note_request(wwte_pkg::cmd_t cmd, logic [wwte_pkg::TIME_W-1:0] batch_time,
                               logic [wwte_pkg::SIZE_W-1:0] batch_size,
                               logic [wwte_pkg::FILES_W-1:0] files_left);
        logic [wwte_pkg::ENTRY_W-1:0] entry;
        logic [wwte_pkg::ENTRY_W-1:0] numer;
        if (cmd == wwte_pkg::CMD_PUSH)
        begin
            numer = {batch_time, 16'h0000};
            if (batch_size == '0)
            begin
                entry = '1;
            end
            else
            begin
                entry = numer / wwte_pkg::ENTRY_W'(batch_size);
            end
            ring_times[oldest_slot] = entry;
            oldest_slot = (oldest_slot + 1) % wwte_pkg::WINDOW_DEPTH;
            if (oldest_slot == 0)
            begin
                ring_full = 1'b1;
            end
        end
        else if (!ring_full)
        begin
            pending.push_back('{time_left: '0, estimate_ready: 1'b0});
        end
        else
        begin
            pending.push_back('{time_left: scaled_estimate(files_left), estimate_ready: 1'b1});
        end
    endfunction

    function void check_estimate(logic [wwte_pkg::TIME_W-1:0] time_left, logic estimate_ready);
        estimate_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result item: time_left=%0d estimate_ready=%0d",
                   time_left, estimate_ready);
            failures++;
            return;
        end
        want = pending.pop_front();
        if (time_left !== want.time_left)
        begin
            $error("time_left: expected %0d, actual %0d", want.time_left, time_left);
            failures++;
        end
        if (estimate_ready !== want.estimate_ready)
        begin
            $error("estimate_ready: expected %0d, actual %0d", want.estimate_ready,
                   estimate_ready);
            failures++;
        end
    endfunction
endclass

module weighted_window_time_estimator_top_test;
    import wwte_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned CALM_ITEMS   = 150;

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;

    estimate_ledger ledger;

    wwte_in_if  req_ch();
    wwte_out_if res_ch();

    weighted_window_time_estimator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_request(cmd_t cmd, logic [TIME_W-1:0] batch_time,
                                logic [SIZE_W-1:0] batch_size, logic [FILES_W-1:0] files_left);
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.batch_time <= batch_time;
        req_ch.batch_size <= batch_size;
        req_ch.files_left <= files_left;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        ledger.note_request(cmd, batch_time, batch_size, files_left);
    endtask

    task automatic pause_requests(int unsigned cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [31:0] spread_value(int unsigned max_bits);
        int unsigned bits;
        bits = $urandom_range(0, max_bits);
        if (bits == 0)
        begin
            return '0;
        end
        return $urandom & (32'hFFFF_FFFF >> (32 - bits));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            ledger.check_estimate(res_ch.time_left, res_ch.estimate_ready);
        end
    end

    initial
    begin
        int unsigned span;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (calm || $urandom_range(0, 2) != 0)
            begin
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                   : $urandom_range(1, 15);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                span = $urandom_range(1, 15);
                res_ch.ready <= 1'b0;
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned        n;
        cmd_t               cmd;
        logic [TIME_W-1:0]  batch_time;
        logic [SIZE_W-1:0]  batch_size;
        logic [FILES_W-1:0] files_left;

        ledger = new();
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_PUSH;
        req_ch.batch_time <= '0;
        req_ch.batch_size <= '0;
        req_ch.files_left <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // not ready yet, then saturated and extreme entries
        send_request(CMD_QUERY, '1, '1, '1);
        send_request(CMD_QUERY, '0, '0, '0);
        send_request(CMD_PUSH, '0, '0, '1);
        send_request(CMD_PUSH, '1, 16'd1, '0);
        send_request(CMD_PUSH, '1, '1, '0);
        send_request(CMD_PUSH, '0, 16'd1, '0);
        send_request(CMD_QUERY, '0, '0, 31'd1000);
        send_request(CMD_PUSH, 32'd1, '1, '0);
        send_request(CMD_PUSH, 32'd12345, 16'd7, '0);
        send_request(CMD_PUSH, 32'h5555_5555, 16'hAAAA, '0);
        send_request(CMD_PUSH, 32'hAAAA_AAAA, 16'h5555, '0);
        send_request(CMD_QUERY, '0, '0, '1);
        send_request(CMD_QUERY, '0, '0, '0);
        send_request(CMD_QUERY, '0, '0, 31'd1);
        for (n = 0; n < WINDOW_DEPTH; n++)
        begin
            send_request(CMD_PUSH, 32'(n + 1), 16'd1, '0);
        end
        send_request(CMD_QUERY, '0, '0, 31'd1);
        send_request(CMD_QUERY, '0, '0, 31'h5555_5555);
        send_request(CMD_QUERY, '0, '0, 31'h2AAA_AAAA);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                pause_requests($urandom_range(1, 15));
            end
            cmd        = ($urandom_range(0, 99) < 55) ? CMD_PUSH : CMD_QUERY;
            batch_time = ($urandom_range(0, 15) == 0) ? '1 : spread_value(32);
            case ($urandom_range(0, 15))
                0:       batch_size = '0;
                1, 2, 3: batch_size = SIZE_W'($urandom_range(1, 16));
                4, 5:    batch_size = SIZE_W'($urandom);
                default: batch_size = SIZE_W'(spread_value(16));
            endcase
            case ($urandom_range(0, 15))
                0:       files_left = '0;
                1:       files_left = '1;
                default: files_left = FILES_W'(spread_value(31));
            endcase
            send_request(cmd, batch_time, batch_size, files_left);
        end
        req_ch.valid <= 1'b0;

        while (ledger.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        if (ledger.failures == 0 && ledger.pending.size() == 0)
        begin
            $display("weighted_window_time_estimator_top_test: PASS");
        end
        else
        begin
            $display("weighted_window_time_estimator_top_test: FAIL");
        end
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("weighted_window_time_estimator_top_test: FAIL");
        $finish;
    end
endmodule
